/* hdl/rrs_pkg.sv */
`default_nettype none
package rrs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIMW_W     = $clog2(MAX_WIDTH + 1);
    localparam int DIMH_W     = $clog2(MAX_HEIGHT + 1);

    localparam int DIM_CFG_W   = 7;
    localparam int SPP_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int WIDTH_RESET   = 64;
    localparam int HEIGHT_RESET  = 64;
    localparam int SAMPLES_RESET = 1;

    localparam int COORD_W    = 17;
    localparam int COORD_FRAC = 16;
    localparam int RAD_W      = 32;
    localparam int ALPHA_W    = 17;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 4 * BYTE_W;

    localparam int DIV_STEPS  = RAD_W;
    localparam int ROOT_STEPS = BYTE_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES = 2'd2;

    typedef enum logic [1:0] {
        OP_RESOLVE = 2'd0,
        OP_RAW     = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_ADDR,
        ST_DIV,
        ST_ROOT,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic prep;
        logic addr;
        logic div_step;
        logic root_step;
        logic write;
        logic read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
        logic clear_last;
    } status_t;

endpackage
`default_nettype wire

/* hdl/radiance_resolve_rgba_store_core.sv */
`default_nettype none
// RGBA8 framebuffer (64 x 64 words, red in the top byte) with a resolve path:
// a resolve write divides each Q16.16 color by the sample count and takes a
// square root for gamma 2, a raw write scales colors straight to bytes, and a
// read maps Q1.16 positions onto the image. After reset the block runs a clearing
// pass, one word a cycle, and takes no request until it ends; configuration
// writes are taken at any time. One request is in flight at a time. Each request
// passes the prepare and address states; a resolve write then runs the
// bit-serial dividers (one quotient bit a cycle, the three colors in parallel)
// and the 8-step root before its write, a raw write goes to its write, a read to
// its read, a dropped write or an unused code to completion. The completion
// cycle waits while the previous result is still stalled in the output register.
module radiance_resolve_rgba_store_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rrs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        operation,
    input  wire logic [rrs_pkg::COORD_W-1:0]       coord_x,
    input  wire logic [rrs_pkg::COORD_W-1:0]       coord_y,
    input  wire logic [rrs_pkg::RAD_W-1:0]         red_in,
    input  wire logic [rrs_pkg::RAD_W-1:0]         green_in,
    input  wire logic [rrs_pkg::RAD_W-1:0]         blue_in,
    input  wire logic [rrs_pkg::ALPHA_W-1:0]       alpha_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [rrs_pkg::BYTE_W-1:0]        red_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        green_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        blue_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        alpha_out,
    output logic                                   range_error
);

    rrs_pkg::cmd_t    cmd;
    rrs_pkg::status_t status;

    rrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rrs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .alpha_in    (alpha_in),
        .cmd         (cmd),
        .status      (status),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .alpha_out   (alpha_out),
        .range_error (range_error)
    );

endmodule
`default_nettype wire

/* hdl/rrs_lane.sv */
`default_nettype none
module rrs_lane (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        div_step,
    input  wire logic                        root_step,
    input  wire logic [rrs_pkg::RAD_W-1:0]   radiance,
    input  wire logic [rrs_pkg::SPP_W-1:0]   divisor,
    output logic      [rrs_pkg::BYTE_W-1:0]  resolve_byte,
    output logic      [rrs_pkg::BYTE_W-1:0]  raw_byte
);

    localparam int HALF_W = rrs_pkg::RAD_W / 2;

    logic [rrs_pkg::RAD_W-1:0]  quo_reg, quo_next;
    logic [rrs_pkg::SPP_W-1:0]  rem_reg, rem_next;
    logic [rrs_pkg::SPP_W-1:0]  div_reg;
    logic [rrs_pkg::BYTE_W-1:0] root_reg, root_next;
    logic [rrs_pkg::BYTE_W-1:0] bit_reg, bit_next;

    logic [rrs_pkg::SPP_W:0]    rem_shift;
    logic [rrs_pkg::SPP_W:0]    rem_diff;
    logic                       fits;
    logic [rrs_pkg::BYTE_W-1:0] trial;
    logic [2*rrs_pkg::BYTE_W-1:0] trial_sq;
    logic                       sat;

    // one quotient bit per step, quotient shifts in where the dividend leaves
    assign rem_shift = {rem_reg, quo_reg[rrs_pkg::RAD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;
    assign sat      = quo_reg[rrs_pkg::RAD_W-1:HALF_W] != '0;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (load)
        begin
            quo_next  = radiance;
            rem_next  = '0;
            root_next = '0;
            bit_next  = {1'b1, {(rrs_pkg::BYTE_W-1){1'b0}}};
        end
        else if (div_step)
        begin
            quo_next = {quo_reg[rrs_pkg::RAD_W-2:0], fits};
            rem_next = fits ? rem_diff[rrs_pkg::SPP_W-1:0] : rem_shift[rrs_pkg::SPP_W-1:0];
        end
        else if (root_step)
        begin
            if (trial_sq <= quo_reg[HALF_W-1:0])
            begin
                root_next = trial;
            end
            bit_next = bit_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        if (load)
        begin
            div_reg <= divisor;
        end
    end

    assign resolve_byte = sat ? '1 : root_reg;
    assign raw_byte     = sat ? '1 : quo_reg[2*rrs_pkg::BYTE_W-1:rrs_pkg::BYTE_W];

endmodule
`default_nettype wire

/* hdl/rrs_datapath.sv */
`default_nettype none
module rrs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rrs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [1:0]                        operation,
    input  wire logic [rrs_pkg::COORD_W-1:0]       coord_x,
    input  wire logic [rrs_pkg::COORD_W-1:0]       coord_y,
    input  wire logic [rrs_pkg::RAD_W-1:0]         red_in,
    input  wire logic [rrs_pkg::RAD_W-1:0]         green_in,
    input  wire logic [rrs_pkg::RAD_W-1:0]         blue_in,
    input  wire logic [rrs_pkg::ALPHA_W-1:0]       alpha_in,
    input  wire rrs_pkg::cmd_t                     cmd,
    output rrs_pkg::status_t                       status,
    output logic      [rrs_pkg::BYTE_W-1:0]        red_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        green_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        blue_out,
    output logic      [rrs_pkg::BYTE_W-1:0]        alpha_out,
    output logic                                   range_error
);

    localparam int SX_W    = rrs_pkg::COORD_W + rrs_pkg::COL_W;
    localparam int SY_W    = rrs_pkg::COORD_W + rrs_pkg::ROW_W;
    localparam int AP_W    = rrs_pkg::ROW_W + rrs_pkg::DIMW_W;
    localparam int APROD_W = rrs_pkg::ALPHA_W + rrs_pkg::BYTE_W;
    localparam int B       = rrs_pkg::BYTE_W;

    // configuration
    logic [rrs_pkg::DIM_CFG_W-1:0] width_cfg_reg;
    logic [rrs_pkg::DIM_CFG_W-1:0] height_cfg_reg;
    logic [rrs_pkg::SPP_W-1:0]     spp_reg;
    logic [rrs_pkg::DIMW_W-1:0]    w_eff;
    logic [rrs_pkg::DIMH_W-1:0]    h_eff;
    logic [rrs_pkg::SPP_W-1:0]     divisor;

    // captured request
    rrs_pkg::op_t                  op_reg;
    logic [rrs_pkg::COORD_W-1:0]   x_reg;
    logic [rrs_pkg::COORD_W-1:0]   y_reg;
    logic                          in_range_reg;
    logic [B-1:0]                  alpha_byte_reg;
    logic                          in_range_next;
    logic [APROD_W-1:0]            alpha_prod;
    logic [B-1:0]                  alpha_byte;

    // coordinate and address
    logic [rrs_pkg::COL_W-1:0]     wm1;
    logic [rrs_pkg::ROW_W-1:0]     hm1;
    logic [SX_W-1:0]               sx_prod;
    logic [SY_W-1:0]               sy_prod;
    logic [SX_W-rrs_pkg::COORD_FRAC-1:0] sx_hi;
    logic [SY_W-rrs_pkg::COORD_FRAC-1:0] sy_hi;
    logic [rrs_pkg::COL_W-1:0]     col_reg, col_next;
    logic [rrs_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [AP_W-1:0]               addr_prod;
    logic [rrs_pkg::ADDR_W-1:0]    addr_reg;

    // memory
    logic [rrs_pkg::WORD_W-1:0]    mem [rrs_pkg::DEPTH];
    logic [rrs_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic                          mem_we;
    logic [rrs_pkg::ADDR_W-1:0]    mem_addr;
    logic [rrs_pkg::WORD_W-1:0]    mem_wdata;
    logic [rrs_pkg::WORD_W-1:0]    rd_data_reg;
    logic [rrs_pkg::WORD_W-1:0]    pixel_word;

    // lanes
    logic [B-1:0] red_res, green_res, blue_res;
    logic [B-1:0] red_raw, green_raw, blue_raw;

    // output register
    logic [B-1:0] red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;
    logic         range_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= rrs_pkg::DIM_CFG_W'(rrs_pkg::WIDTH_RESET);
            height_cfg_reg <= rrs_pkg::DIM_CFG_W'(rrs_pkg::HEIGHT_RESET);
            spp_reg        <= rrs_pkg::SPP_W'(rrs_pkg::SAMPLES_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrs_pkg::CFG_WIDTH:   width_cfg_reg  <= cfg_data[rrs_pkg::DIM_CFG_W-1:0];
                rrs_pkg::CFG_HEIGHT:  height_cfg_reg <= cfg_data[rrs_pkg::DIM_CFG_W-1:0];
                rrs_pkg::CFG_SAMPLES: spp_reg        <= cfg_data[rrs_pkg::SPP_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate size registers into 1..max, zero samples counts as one
    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = rrs_pkg::DIMW_W'(1);
        else if (int'(width_cfg_reg) > rrs_pkg::MAX_WIDTH)
            w_eff = rrs_pkg::DIMW_W'(rrs_pkg::MAX_WIDTH);
        else
            w_eff = rrs_pkg::DIMW_W'(width_cfg_reg);

        if (height_cfg_reg == '0)
            h_eff = rrs_pkg::DIMH_W'(1);
        else if (int'(height_cfg_reg) > rrs_pkg::MAX_HEIGHT)
            h_eff = rrs_pkg::DIMH_W'(rrs_pkg::MAX_HEIGHT);
        else
            h_eff = rrs_pkg::DIMH_W'(height_cfg_reg);
    end

    assign divisor = (spp_reg == '0) ? rrs_pkg::SPP_W'(1) : spp_reg;

    assign in_range_next = (coord_x < rrs_pkg::COORD_W'(w_eff))
                        && (coord_y < rrs_pkg::COORD_W'(h_eff));

    // alpha*255 as alpha*256 - alpha, then drop the fraction
    assign alpha_prod = {alpha_in, {B{1'b0}}} - APROD_W'(alpha_in);
    assign alpha_byte = alpha_prod[APROD_W-1] ? '1
                      : alpha_prod[APROD_W-2:rrs_pkg::COORD_FRAC];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= rrs_pkg::op_t'(operation);
            x_reg          <= coord_x;
            y_reg          <= coord_y;
            in_range_reg   <= in_range_next;
            alpha_byte_reg <= alpha_byte;
        end
    end

    // scale normalized position onto the last column / row
    assign wm1     = rrs_pkg::COL_W'(w_eff - rrs_pkg::DIMW_W'(1));
    assign hm1     = rrs_pkg::ROW_W'(h_eff - rrs_pkg::DIMH_W'(1));
    assign sx_prod = SX_W'(x_reg) * SX_W'(wm1);
    assign sy_prod = SY_W'(y_reg) * SY_W'(hm1);
    assign sx_hi   = sx_prod[SX_W-1:rrs_pkg::COORD_FRAC];
    assign sy_hi   = sy_prod[SY_W-1:rrs_pkg::COORD_FRAC];

    always_comb
    begin
        if (op_reg == rrs_pkg::OP_READ)
        begin
            col_next = (sx_hi > (SX_W-rrs_pkg::COORD_FRAC)'(wm1))
                     ? wm1 : sx_hi[rrs_pkg::COL_W-1:0];
            row_next = (sy_hi > (SY_W-rrs_pkg::COORD_FRAC)'(hm1))
                     ? hm1 : sy_hi[rrs_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = x_reg[rrs_pkg::COL_W-1:0];
            row_next = y_reg[rrs_pkg::ROW_W-1:0];
        end
    end

    assign addr_prod = AP_W'(row_reg) * AP_W'(w_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.addr)
        begin
            addr_reg <= rrs_pkg::ADDR_W'(addr_prod) + rrs_pkg::ADDR_W'(col_reg);
        end
    end

    rrs_lane u_red (
        .clk          (clk),
        .load         (cmd.load),
        .div_step     (cmd.div_step),
        .root_step    (cmd.root_step),
        .radiance     (red_in),
        .divisor      (divisor),
        .resolve_byte (red_res),
        .raw_byte     (red_raw)
    );

    rrs_lane u_green (
        .clk          (clk),
        .load         (cmd.load),
        .div_step     (cmd.div_step),
        .root_step    (cmd.root_step),
        .radiance     (green_in),
        .divisor      (divisor),
        .resolve_byte (green_res),
        .raw_byte     (green_raw)
    );

    rrs_lane u_blue (
        .clk          (clk),
        .load         (cmd.load),
        .div_step     (cmd.div_step),
        .root_step    (cmd.root_step),
        .radiance     (blue_in),
        .divisor      (divisor),
        .resolve_byte (blue_res),
        .raw_byte     (blue_raw)
    );

    assign pixel_word = (op_reg == rrs_pkg::OP_RESOLVE)
                      ? {red_res, green_res, blue_res, alpha_byte_reg}
                      : {red_raw, green_raw, blue_raw, alpha_byte_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + rrs_pkg::ADDR_W'(1);
        end
    end

    assign mem_we    = cmd.clear_step || cmd.write;
    assign mem_addr  = cmd.clear_step ? clr_addr_reg : addr_reg;
    assign mem_wdata = cmd.clear_step ? '0 : pixel_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (op_reg)
                rrs_pkg::OP_READ:
                begin
                    red_out_reg     <= rd_data_reg[4*B-1:3*B];
                    green_out_reg   <= rd_data_reg[3*B-1:2*B];
                    blue_out_reg    <= rd_data_reg[2*B-1:B];
                    alpha_out_reg   <= rd_data_reg[B-1:0];
                    range_error_reg <= 1'b0;
                end
                rrs_pkg::OP_RESOLVE, rrs_pkg::OP_RAW:
                begin
                    red_out_reg     <= '0;
                    green_out_reg   <= '0;
                    blue_out_reg    <= '0;
                    alpha_out_reg   <= '0;
                    range_error_reg <= !in_range_reg;
                end
                default:
                begin
                    red_out_reg     <= '0;
                    green_out_reg   <= '0;
                    blue_out_reg    <= '0;
                    alpha_out_reg   <= '0;
                    range_error_reg <= 1'b0;
                end
            endcase
        end
    end

    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign alpha_out   = alpha_out_reg;
    assign range_error = range_error_reg;

    assign status.op         = op_reg;
    assign status.in_range   = in_range_reg;
    assign status.clear_last = clr_addr_reg == rrs_pkg::ADDR_W'(rrs_pkg::DEPTH - 1);

    a_write_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (in_range_reg
                       && (op_reg == rrs_pkg::OP_RESOLVE || op_reg == rrs_pkg::OP_RAW)))
        else $error("pixel write for a request outside the image");

    a_write_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (int'(addr_reg) < int'(w_eff) * int'(h_eff)))
        else $error("pixel write address beyond the image");

    a_read_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.prep) && op_reg == rrs_pkg::OP_READ)
            |-> (int'(col_reg) < int'(w_eff) && int'(row_reg) < int'(h_eff)))
        else $error("scaled read position outside the image");

endmodule
`default_nettype wire

/* hdl/rrs_ctrl.sv */
`default_nettype none
module rrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire rrs_pkg::status_t  status,
    output rrs_pkg::cmd_t          cmd
);

    rrs_pkg::state_t             state_reg, state_next;
    logic [rrs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrs_pkg::ST_CLEAR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            rrs_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = rrs_pkg::ST_IDLE;
            end
            rrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rrs_pkg::ST_PREP;
                end
            end
            rrs_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = rrs_pkg::ST_ADDR;
            end
            rrs_pkg::ST_ADDR:
            begin
                cmd.addr  = 1'b1;
                step_next = '0;
                case (status.op)
                    rrs_pkg::OP_READ:
                        state_next = rrs_pkg::ST_READ;
                    rrs_pkg::OP_RESOLVE:
                        state_next = status.in_range ? rrs_pkg::ST_DIV : rrs_pkg::ST_DONE;
                    rrs_pkg::OP_RAW:
                        state_next = status.in_range ? rrs_pkg::ST_WRITE : rrs_pkg::ST_DONE;
                    default:
                        state_next = rrs_pkg::ST_DONE;
                endcase
            end
            rrs_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + rrs_pkg::STEP_W'(1);
                if (step_reg == rrs_pkg::STEP_W'(rrs_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = rrs_pkg::ST_ROOT;
                end
            end
            rrs_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + rrs_pkg::STEP_W'(1);
                if (step_reg == rrs_pkg::STEP_W'(rrs_pkg::ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = rrs_pkg::ST_WRITE;
                end
            end
            rrs_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = rrs_pkg::ST_DONE;
            end
            rrs_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = rrs_pkg::ST_DONE;
            end
            rrs_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign in_stall  = state_reg != rrs_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while one is in flight");

    a_div_then_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrs_pkg::ST_DIV
         && step_reg == rrs_pkg::STEP_W'(rrs_pkg::DIV_STEPS - 1))
            |=> (state_reg == rrs_pkg::ST_ROOT && step_reg == '0))
        else $error("division did not hand over to the root steps");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rrs_pkg::ST_DONE))
        else $error("result raised outside the completion state");

endmodule
`default_nettype wire

/* bench/tb_radiance_resolve_rgba_store_core.sv */
`default_nettype none
module tb_radiance_resolve_rgba_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rrs_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        rrs_pkg::op_t                op;
        logic [rrs_pkg::COORD_W-1:0] x;
        logic [rrs_pkg::COORD_W-1:0] y;
        logic [rrs_pkg::RAD_W-1:0]   r;
        logic [rrs_pkg::RAD_W-1:0]   g;
        logic [rrs_pkg::RAD_W-1:0]   b;
        logic [rrs_pkg::ALPHA_W-1:0] a;
    } request_t;

    typedef struct {
        logic [rrs_pkg::BYTE_W-1:0] red;
        logic [rrs_pkg::BYTE_W-1:0] green;
        logic [rrs_pkg::BYTE_W-1:0] blue;
        logic [rrs_pkg::BYTE_W-1:0] alpha;
        logic                       range_err;
    } pixel_result_t;

    class frame_scoreboard;
        logic [rrs_pkg::WORD_W-1:0]    frame_words [rrs_pkg::DEPTH];
        logic [rrs_pkg::DIM_CFG_W-1:0] width_reg;
        logic [rrs_pkg::DIM_CFG_W-1:0] height_reg;
        logic [rrs_pkg::SPP_W-1:0]     samples_reg;
        pixel_result_t                 awaited[$];
        int                            mismatches;

        function new();
            foreach (frame_words[i])
                frame_words[i] = '0;
            width_reg   = rrs_pkg::DIM_CFG_W'(rrs_pkg::WIDTH_RESET);
            height_reg  = rrs_pkg::DIM_CFG_W'(rrs_pkg::HEIGHT_RESET);
            samples_reg = rrs_pkg::SPP_W'(rrs_pkg::SAMPLES_RESET);
            mismatches  = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > rrs_pkg::MAX_WIDTH)
                return rrs_pkg::MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > rrs_pkg::MAX_HEIGHT)
                return rrs_pkg::MAX_HEIGHT;
            return int'(height_reg);
        endfunction

        function int eff_samples();
            return (samples_reg == 0) ? 1 : int'(samples_reg);
        endfunction

        function void set_register(logic [rrs_pkg::CFG_INDEX_W-1:0] index,
                                   logic [rrs_pkg::CFG_DATA_W-1:0] data);
            case (index)
                rrs_pkg::CFG_WIDTH:   width_reg = data[rrs_pkg::DIM_CFG_W-1:0];
                rrs_pkg::CFG_HEIGHT:  height_reg = data[rrs_pkg::DIM_CFG_W-1:0];
                rrs_pkg::CFG_SAMPLES: samples_reg = data[rrs_pkg::SPP_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(sqrt(v)), saturated at one byte
        function logic [rrs_pkg::BYTE_W-1:0] root_byte(logic [31:0] v);
            logic [7:0]  root;
            logic [7:0]  trial;
            logic [15:0] square;
            int          bitpos;
            if (v >= 32'h1_0000)
                return 8'hFF;
            root = '0;
            for (bitpos = 7; bitpos >= 0; bitpos--)
            begin
                trial  = root | (8'd1 << bitpos);
                square = trial * trial;
                if ({16'd0, square} <= v)
                    root = trial;
            end
            return root;
        endfunction

        function logic [rrs_pkg::BYTE_W-1:0] gamma_byte(logic [rrs_pkg::RAD_W-1:0] c);
            logic [31:0] quotient;
            quotient = c / 32'(eff_samples());
            return root_byte(quotient);
        endfunction

        function logic [rrs_pkg::BYTE_W-1:0] raw_byte(logic [rrs_pkg::RAD_W-1:0] c);
            if (c[31:16] != 0)
                return 8'hFF;
            return c[15:8];
        endfunction

        function logic [rrs_pkg::BYTE_W-1:0] alpha_byte(logic [rrs_pkg::ALPHA_W-1:0] a);
            logic [24:0] prod;
            prod = a * 8'd255;
            if (prod[24:16] > 9'd255)
                return 8'hFF;
            return prod[23:16];
        endfunction

        function int scale_coord(logic [rrs_pkg::COORD_W-1:0] c, int size);
            logic [23:0] prod;
            int          v;
            prod = c * 7'(size - 1);
            v    = int'(prod >> rrs_pkg::COORD_FRAC);
            return (v > size - 1) ? size - 1 : v;
        endfunction

        function void note_request(request_t q);
            pixel_result_t              res;
            int                         w;
            int                         h;
            int                         col;
            int                         row;
            logic [rrs_pkg::WORD_W-1:0] word;
            res = '{default: '0};
            w   = eff_width();
            h   = eff_height();
            case (q.op)
                rrs_pkg::OP_RESOLVE, rrs_pkg::OP_RAW:
                begin
                    if (q.x >= w || q.y >= h)
                        res.range_err = 1'b1;
                    else
                    begin
                        if (q.op == rrs_pkg::OP_RESOLVE)
                            word = {gamma_byte(q.r), gamma_byte(q.g), gamma_byte(q.b),
                                    alpha_byte(q.a)};
                        else
                            word = {raw_byte(q.r), raw_byte(q.g), raw_byte(q.b),
                                    alpha_byte(q.a)};
                        frame_words[int'(q.y) * w + int'(q.x)] = word;
                    end
                end
                rrs_pkg::OP_READ:
                begin
                    col       = scale_coord(q.x, w);
                    row       = scale_coord(q.y, h);
                    word      = frame_words[row * w + col];
                    res.red   = word[31:24];
                    res.green = word[23:16];
                    res.blue  = word[15:8];
                    res.alpha = word[7:0];
                end
                default: ;
            endcase
            awaited.push_back(res);
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.red !== want.red)
            begin
                $error("red_out: expected %0d, got %0d", want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green)
            begin
                $error("green_out: expected %0d, got %0d", want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                mismatches++;
            end
            if (got.alpha !== want.alpha)
            begin
                $error("alpha_out: expected %0d, got %0d", want.alpha, got.alpha);
                mismatches++;
            end
            if (got.range_err !== want.range_err)
            begin
                $error("range_error: expected %0d, got %0d", want.range_err, got.range_err);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rrs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rrs_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [1:0]                      operation;
    logic [rrs_pkg::COORD_W-1:0]     coord_x;
    logic [rrs_pkg::COORD_W-1:0]     coord_y;
    logic [rrs_pkg::RAD_W-1:0]       red_in;
    logic [rrs_pkg::RAD_W-1:0]       green_in;
    logic [rrs_pkg::RAD_W-1:0]       blue_in;
    logic [rrs_pkg::ALPHA_W-1:0]     alpha_in;
    logic                            out_valid;
    logic                            out_stall;
    logic [rrs_pkg::BYTE_W-1:0]      red_out;
    logic [rrs_pkg::BYTE_W-1:0]      green_out;
    logic [rrs_pkg::BYTE_W-1:0]      blue_out;
    logic [rrs_pkg::BYTE_W-1:0]      alpha_out;
    logic                            range_error;

    frame_scoreboard sb;
    int              sender_idle_pct = 0;
    int              receiver_stall_pct = 0;
    int              painted_col[$];
    int              painted_row[$];

    radiance_resolve_rgba_store_core dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request('{rrs_pkg::op_t'(operation), coord_x, coord_y, red_in, green_in,
                              blue_in, alpha_in});
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{red_out, green_out, blue_out, alpha_out, range_error});
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(request_t q);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= q.op;
        coord_x   <= q.x;
        coord_y   <= q.y;
        red_in    <= q.r;
        green_in  <= q.g;
        blue_in   <= q.b;
        alpha_in  <= q.a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_register(logic [rrs_pkg::CFG_INDEX_W-1:0] index,
                                  logic [rrs_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(index, data);
    endtask

    function automatic request_t make_request(rrs_pkg::op_t op, int x, int y, logic [31:0] r,
                                              logic [31:0] g, logic [31:0] b, int a);
        return '{op, rrs_pkg::COORD_W'(x), rrs_pkg::COORD_W'(y), r, g, b,
                 rrs_pkg::ALPHA_W'(a)};
    endfunction

    function automatic logic [rrs_pkg::RAD_W-1:0] pick_radiance(rrs_pkg::op_t op);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default:
                if (op == rrs_pkg::OP_RESOLVE)
                    return $urandom_range(0, sb.eff_samples() * 32'h1_0000 - 1);
                else
                    return $urandom_range(0, 32'h1_0400);
        endcase
    endfunction

    function automatic int pick_alpha();
        case ($urandom_range(7))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(0, 17'h1_FFFF);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // smallest Q1.16 position that lands on pixel index idx
    function automatic int target_coord(int idx, int size);
        if (size == 1)
            return $urandom_range(0, 65536);
        return (idx * 65536 + size - 2) / (size - 1);
    endfunction

    function automatic request_t random_request();
        request_t q;
        int       w;
        int       h;
        int       pick;
        int       roll;
        w    = sb.eff_width();
        h    = sb.eff_height();
        roll = $urandom_range(99);
        q.op = (roll < 35) ? rrs_pkg::OP_RESOLVE : (roll < 60) ? rrs_pkg::OP_RAW
             : (roll < 95) ? rrs_pkg::OP_READ : rrs_pkg::OP_NONE;
        q.r  = pick_radiance(q.op);
        q.g  = pick_radiance(q.op);
        q.b  = pick_radiance(q.op);
        q.a  = rrs_pkg::ALPHA_W'(pick_alpha());
        if (q.op == rrs_pkg::OP_READ)
        begin
            if (painted_col.size() != 0 && $urandom_range(99) < 60)
            begin
                pick = $urandom_range(0, painted_col.size() - 1);
                q.x  = rrs_pkg::COORD_W'(target_coord(painted_col[pick], w));
                q.y  = rrs_pkg::COORD_W'(target_coord(painted_row[pick], h));
            end
            else if ($urandom_range(9) == 0)
            begin
                q.x = rrs_pkg::COORD_W'($urandom_range(0, 17'h1_FFFF));
                q.y = rrs_pkg::COORD_W'($urandom_range(0, 17'h1_FFFF));
            end
            else
            begin
                q.x = rrs_pkg::COORD_W'($urandom_range(0, 65536));
                q.y = rrs_pkg::COORD_W'($urandom_range(0, 65536));
            end
        end
        else if ($urandom_range(99) < 85)
        begin
            q.x = rrs_pkg::COORD_W'($urandom_range(0, w - 1));
            q.y = rrs_pkg::COORD_W'($urandom_range(0, h - 1));
            if (q.op != rrs_pkg::OP_NONE)
            begin
                painted_col.push_back(int'(q.x));
                painted_row.push_back(int'(q.y));
                if (painted_col.size() > 16)
                begin
                    void'(painted_col.pop_front());
                    void'(painted_row.pop_front());
                end
            end
        end
        else if ($urandom_range(1) == 0)
        begin
            q.x = rrs_pkg::COORD_W'($urandom_range(0, w + 2));
            q.y = rrs_pkg::COORD_W'($urandom_range(h, h + 2));
        end
        else
        begin
            q.x = rrs_pkg::COORD_W'($urandom_range(0, 17'h1_FFFF));
            q.y = rrs_pkg::COORD_W'($urandom_range(0, 17'h1_FFFF));
        end
        return q;
    endfunction

    task automatic run_phase(int w, int h, int spp, int idle_pct, int stall_pct, int count);
        // drain before touching registers
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_register(rrs_pkg::CFG_WIDTH, rrs_pkg::CFG_DATA_W'(w));
        write_register(rrs_pkg::CFG_HEIGHT, rrs_pkg::CFG_DATA_W'(h));
        write_register(rrs_pkg::CFG_SAMPLES, rrs_pkg::CFG_DATA_W'(spp));
        write_register(CFG_SPARE, rrs_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        painted_col.delete();
        painted_row.delete();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        int sender_modes[4];
        int receiver_modes[4];
        int pass;
        int w;
        int h;
        int spp;
        sender_modes   = '{0, 50, 0, 31};
        receiver_modes = '{0, 0, 50, 31};
        sb = new();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= rrs_pkg::CFG_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        operation <= rrs_pkg::OP_NONE;
        coord_x   <= '0;
        coord_y   <= '0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        alpha_in  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // corners, saturation, dropped writes and the unused code at reset settings
        send_request(make_request(rrs_pkg::OP_RESOLVE, 0, 0, 32'h0, 32'hFFFF_FFFF,
                                  32'h0000_FFFF, 0));
        send_request(make_request(rrs_pkg::OP_READ, 0, 0, $urandom, $urandom, $urandom, 0));
        send_request(make_request(rrs_pkg::OP_RESOLVE, 63, 63, 32'h0001_0000, 32'h0000_FFFF,
                                  32'h4, 65536));
        send_request(make_request(rrs_pkg::OP_READ, 65536, 65536, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_RAW, 1, 0, 32'h0000_FF00, 32'h0000_FFFF,
                                  32'h0100_0000, 17'h1_FFFF));
        send_request(make_request(rrs_pkg::OP_READ, target_coord(1, 64), 0, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_RAW, 63, 0, 32'hFF, 32'h100, 32'hFFFF_FFFF,
                                  32768));
        send_request(make_request(rrs_pkg::OP_READ, 17'h1_FFFF, 0, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_RESOLVE, 64, 0, $urandom, $urandom, $urandom,
                                  100));
        send_request(make_request(rrs_pkg::OP_RAW, 0, 64, $urandom, $urandom, $urandom, 100));
        send_request(make_request(rrs_pkg::OP_RESOLVE, 17'h1_FFFF, 17'h1_FFFF, '1, '1, '1,
                                  17'h1_FFFF));
        send_request(make_request(rrs_pkg::OP_NONE, $urandom_range(0, 63), 0, $urandom,
                                  $urandom, $urandom, 65536));
        send_request(make_request(rrs_pkg::OP_READ, 32'h8000, 32'h8000, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_RAW, 0, 63, 32'h1234, 32'h8000, 32'hFFFF, 1));
        send_request(make_request(rrs_pkg::OP_READ, 0, 17'h1_FFFF, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_RESOLVE, 31, 31, 32'h0000_0F00, 32'h0000_0400,
                                  32'h0000_0001, 65535));
        send_request(make_request(rrs_pkg::OP_READ, 32'h8000, 32'h8000, 0, 0, 0, 0));
        send_request(make_request(rrs_pkg::OP_NONE, 17'h1_FFFF, 17'h1_FFFF, '1, '1, '1,
                                  17'h1_FFFF));
        repeat (100) send_request(random_request());

        // zero and out-of-range register values saturate into the legal range
        run_phase(0, 0, 0, sender_modes[1], receiver_modes[1], 60);
        run_phase(127, 127, 65535, sender_modes[2], receiver_modes[2], 100);
        run_phase(64, 1, 16, sender_modes[3], receiver_modes[3], 80);
        run_phase(1, 64, 1, sender_modes[0], receiver_modes[0], 80);
        for (pass = 0; pass < 5; pass++)
        begin
            w   = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            h   = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            spp = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 8);
            run_phase(w, h, spp, sender_modes[pass % 4], receiver_modes[pass % 4], 100);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hdl/rrs_pkg.sv
hdl/rrs_lane.sv
hdl/rrs_datapath.sv
hdl/rrs_ctrl.sv
hdl/radiance_resolve_rgba_store_core.sv
bench/tb_radiance_resolve_rgba_store_core.sv
